// ----- src/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never hold at a clock edge.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- src/crft_pkg.sv -----
package crft_pkg;

	localparam int unsigned CountW   = 8;
	localparam int unsigned SettleW  = 16;
	localparam int unsigned EdgeW    = 17;
	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 17;

	localparam logic [CountW-1:0]  SampleCountRst  = 8'd16;
	localparam logic [SettleW-1:0] SettleTicksRst  = 16'd20;
	localparam logic [EdgeW-1:0]   TimeoutCountRst = 17'd70000;

	localparam logic [CfgIdxW-1:0] CFG_SAMPLE_COUNT  = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_SETTLE_TICKS  = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_TIMEOUT_COUNT = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_DRAIN  = 3'd1,
		PH_RISE   = 3'd2,
		PH_CHARGE = 3'd3,
		PH_FALL   = 3'd4
	} phase_t;

	typedef struct packed {
		logic             active_drive;
		logic             sensor_drive_enable;
		logic             sensor_drive_high;
		logic             busy_res;
		logic             done_res;
		logic [EdgeW-1:0] reading;
	} result_t;

endpackage

// ----- src/capacitive_rise_fall_timer_unit.sv -----
// Channel | Direction | Handshake         | Payload
// in      | in        | in_valid/in_stall   | action, sensor_level
// out     | out       | out_valid/out_stall | active_drive, sensor_drive_enable,
//         |           |                     | sensor_drive_high, busy_res, done_res, reading
// cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One tick beat is taken per cycle while in_stall is low; the sequencer state updates on the accepting
// edge and the result is written into a two-entry output buffer on that same edge.
// in_stall is decoded from the registered buffer count: it rises only when both buffer entries hold results.
// Reset (arst_n low) returns to idle with the default register values.
// cfg_ready is always high.
`include "assert_macros.svh"

module capacitive_rise_fall_timer_unit
	import crft_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                action,
	input  logic                sensor_level,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                active_drive,
	output logic                sensor_drive_enable,
	output logic                sensor_drive_high,
	output logic                busy_res,
	output logic                done_res,
	output logic [EdgeW-1:0]    reading,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	logic [CountW-1:0]  sample_count_q;
	logic [SettleW-1:0] settle_ticks_q;
	logic [EdgeW-1:0]   timeout_count_q;

	phase_t             phase_q, phase_d;
	logic [SettleW-1:0] settle_q, settle_d;
	logic [EdgeW-1:0]   edge_q, edge_d;
	logic [CountW-1:0]  samples_q, samples_d;
	logic [EdgeW-1:0]   avg_q, avg_d;
	logic [EdgeW-1:0]   last_q, last_d;
	logic               done_d;

	result_t            res_d;
	result_t            buf_q [2];
	logic               wr_ptr_q, rd_ptr_q;
	logic [1:0]         cnt_q;
	logic               push, pop;

	assign cfg_ready = 1'b1;
	assign in_stall  = (cnt_q == 2'd2);
	assign push      = in_valid && !in_stall;
	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q  <= SampleCountRst;
			settle_ticks_q  <= SettleTicksRst;
			timeout_count_q <= TimeoutCountRst;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SAMPLE_COUNT: begin
					sample_count_q <= (cfg_data[CountW-1:0] == '0) ? CountW'(1)
						: cfg_data[CountW-1:0];
				end
				CFG_SETTLE_TICKS: begin
					settle_ticks_q <= (cfg_data[SettleW-1:0] == '0) ? SettleW'(1)
						: cfg_data[SettleW-1:0];
				end
				CFG_TIMEOUT_COUNT: begin
					timeout_count_q <= cfg_data[EdgeW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// next state of the sequencer for the beat on the input
	always_comb begin
		logic [SettleW-1:0] settle_inc;
		logic [EdgeW-1:0]   edge_inc;
		logic [CountW-1:0]  samples_inc;
		logic [EdgeW:0]     sum;
		logic               settle_ok, timed_out, end_now, keep;

		settle_inc  = settle_q + SettleW'(1);
		edge_inc    = edge_q + EdgeW'(1);
		samples_inc = samples_q + CountW'(1);
		sum         = {1'b0, avg_q} + {1'b0, edge_q};
		settle_ok   = (settle_inc >= settle_ticks_q) || (settle_inc == '0);
		timed_out   = (edge_inc >= timeout_count_q);
		end_now     = 1'b0;
		keep        = 1'b0;

		phase_d   = phase_q;
		settle_d  = settle_q;
		edge_d    = edge_q;
		samples_d = samples_q;
		avg_d     = avg_q;
		last_d    = last_q;
		done_d    = 1'b0;

		if (action) begin
			phase_d   = PH_DRAIN;
			settle_d  = '0;
			edge_d    = '0;
			samples_d = '0;
			avg_d     = '0;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
				end
				PH_DRAIN: begin
					settle_d = settle_inc;
					if (settle_ok) begin
						phase_d = PH_RISE;
						edge_d  = '0;
					end
				end
				PH_RISE: begin
					if (sensor_level) begin
						phase_d  = PH_CHARGE;
						settle_d = '0;
					end else begin
						edge_d  = edge_inc;
						end_now = timed_out;
					end
				end
				PH_CHARGE: begin
					settle_d = settle_inc;
					if (settle_ok)
						phase_d = PH_FALL;
				end
				PH_FALL: begin
					if (!sensor_level) begin
						end_now = 1'b1;
						keep    = 1'b1;
					end else begin
						edge_d  = edge_inc;
						end_now = timed_out;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end

		// sample finished: merge (unless timed out) and move on
		if (end_now) begin
			if (keep)
				avg_d = sum[EdgeW:1];
			samples_d = samples_inc;
			edge_d    = '0;
			settle_d  = '0;
			if (samples_inc >= sample_count_q) begin
				last_d  = avg_d;
				phase_d = PH_IDLE;
				done_d  = 1'b1;
			end else begin
				phase_d = PH_DRAIN;
			end
		end
	end

	always_comb begin
		res_d.active_drive        = (phase_d == PH_RISE) || (phase_d == PH_CHARGE);
		res_d.sensor_drive_enable = (phase_d == PH_DRAIN) || (phase_d == PH_CHARGE);
		res_d.sensor_drive_high   = (phase_d == PH_CHARGE);
		res_d.busy_res            = (phase_d != PH_IDLE);
		res_d.done_res            = done_d;
		res_d.reading             = last_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			settle_q  <= '0;
			edge_q    <= '0;
			samples_q <= '0;
			avg_q     <= '0;
			last_q    <= '0;
		end else if (push) begin
			phase_q   <= phase_d;
			settle_q  <= settle_d;
			edge_q    <= edge_d;
			samples_q <= samples_d;
			avg_q     <= avg_d;
			last_q    <= last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			buf_q[wr_ptr_q] <= res_d;
	end

	assign active_drive        = buf_q[rd_ptr_q].active_drive;
	assign sensor_drive_enable = buf_q[rd_ptr_q].sensor_drive_enable;
	assign sensor_drive_high   = buf_q[rd_ptr_q].sensor_drive_high;
	assign busy_res            = buf_q[rd_ptr_q].busy_res;
	assign done_res            = buf_q[rd_ptr_q].done_res;
	assign reading             = buf_q[rd_ptr_q].reading;

	`ASSERT_NEVER(a_buf_overflow, cnt_q == 2'd3, "output buffer count out of range")
	`ASSERT_CLK(a_done_goes_idle, push && done_d |=> phase_q == PH_IDLE,
		"reading completed but sequencer not idle")
	`ASSERT_CLK(a_idle_tick_holds,
		push && !action && phase_q == PH_IDLE |=>
		phase_q == PH_IDLE && last_q == $past(last_q),
		"idle tick changed sequencer state")
	`ASSERT_CLK(a_ptr_count, cnt_q == 2'd1 |-> wr_ptr_q != rd_ptr_q,
		"buffer pointers disagree with count")

endmodule

// ----- sim/crft_checker.sv -----
module crft_checker
	import crft_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic                action,
	input  logic                sensor_level,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic                active_drive,
	input  logic                sensor_drive_enable,
	input  logic                sensor_drive_high,
	input  logic                busy_res,
	input  logic                done_res,
	input  logic [EdgeW-1:0]    reading,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	output int                  n_fail,
	output int                  n_pending
);

	logic [CountW-1:0]  want_samples;
	logic [SettleW-1:0] want_settle;
	logic [EdgeW-1:0]   want_timeout;

	phase_t             ph;
	logic [SettleW-1:0] settle_cnt;
	logic [EdgeW-1:0]   charge_cnt;
	logic [CountW-1:0]  samples_taken;
	logic [EdgeW-1:0]   avg_cnt;
	logic [EdgeW-1:0]   last_avg;

	result_t tick_results_q[$];
	result_t got;
	result_t want;

	// Advance the sequencer by one tick beat and return the pin/status word it leaves.
	task automatic step_sequencer(input logic start, input logic lvl, output result_t r);
		logic            close;
		logic            keep;
		logic            done;
		logic [EdgeW:0]  sum;
		close = 1'b0;
		keep = 1'b0;
		done = 1'b0;
		if (start) begin
			ph = PH_DRAIN;
			settle_cnt = '0;
			charge_cnt = '0;
			samples_taken = '0;
			avg_cnt = '0;
		end else begin
			case (ph)
				PH_DRAIN: begin
					settle_cnt = settle_cnt + SettleW'(1);
					if (settle_cnt >= want_settle || settle_cnt == '0) begin
						ph = PH_RISE;
						charge_cnt = '0;
					end
				end
				PH_RISE: begin
					if (lvl) begin
						ph = PH_CHARGE;
						settle_cnt = '0;
					end else begin
						charge_cnt = charge_cnt + EdgeW'(1);
						close = (charge_cnt >= want_timeout);
					end
				end
				PH_CHARGE: begin
					settle_cnt = settle_cnt + SettleW'(1);
					if (settle_cnt >= want_settle || settle_cnt == '0)
						ph = PH_FALL;
				end
				PH_FALL: begin
					if (!lvl) begin
						close = 1'b1;
						keep = 1'b1;
					end else begin
						charge_cnt = charge_cnt + EdgeW'(1);
						close = (charge_cnt >= want_timeout);
					end
				end
				default: ph = PH_IDLE;
			endcase
		end
		if (close) begin
			// timed-out samples still count but leave the average alone
			if (keep) begin
				sum = {1'b0, avg_cnt} + {1'b0, charge_cnt};
				avg_cnt = sum[EdgeW:1];
			end
			samples_taken = samples_taken + CountW'(1);
			charge_cnt = '0;
			settle_cnt = '0;
			if (samples_taken >= want_samples) begin
				last_avg = avg_cnt;
				ph = PH_IDLE;
				done = 1'b1;
			end else begin
				ph = PH_DRAIN;
			end
		end
		r.active_drive = (ph == PH_RISE || ph == PH_CHARGE);
		r.sensor_drive_enable = (ph == PH_DRAIN || ph == PH_CHARGE);
		r.sensor_drive_high = (ph == PH_CHARGE);
		r.busy_res = (ph != PH_IDLE);
		r.done_res = done;
		r.reading = last_avg;
	endtask

	task automatic check_field(input string field, input logic [EdgeW-1:0] exp_v,
			input logic [EdgeW-1:0] got_v);
		if (exp_v !== got_v) begin
			n_fail = n_fail + 1;
			if (n_fail <= 10)
				$display("mismatch %s: expected %0d, got %0d", field, exp_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_fail = 0;
			want_samples = SampleCountRst;
			want_settle = SettleTicksRst;
			want_timeout = TimeoutCountRst;
			ph = PH_IDLE;
			settle_cnt = '0;
			charge_cnt = '0;
			samples_taken = '0;
			avg_cnt = '0;
			last_avg = '0;
			tick_results_q.delete();
		end else begin
			// pop before push: a beat never returns on the edge it is taken
			if (out_valid && !out_stall) begin
				got = {active_drive, sensor_drive_enable, sensor_drive_high, busy_res,
					done_res, reading};
				if (tick_results_q.size() == 0) begin
					n_fail = n_fail + 1;
					if (n_fail <= 10)
						$display("result beat with nothing outstanding: %h", got);
				end else begin
					want = tick_results_q.pop_front();
					check_field("active_drive", EdgeW'(want.active_drive),
						EdgeW'(got.active_drive));
					check_field("sensor_drive_enable", EdgeW'(want.sensor_drive_enable),
						EdgeW'(got.sensor_drive_enable));
					check_field("sensor_drive_high", EdgeW'(want.sensor_drive_high),
						EdgeW'(got.sensor_drive_high));
					check_field("busy_res", EdgeW'(want.busy_res), EdgeW'(got.busy_res));
					check_field("done_res", EdgeW'(want.done_res), EdgeW'(got.done_res));
					check_field("reading", want.reading, got.reading);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SAMPLE_COUNT: begin
						want_samples = cfg_data[CountW-1:0];
						if (want_samples == '0)
							want_samples = CountW'(1);
					end
					CFG_SETTLE_TICKS: begin
						want_settle = cfg_data[SettleW-1:0];
						if (want_settle == '0)
							want_settle = SettleW'(1);
					end
					CFG_TIMEOUT_COUNT: want_timeout = cfg_data[EdgeW-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				step_sequencer(action, sensor_level, want);
				tick_results_q.push_back(want);
			end
		end
		n_pending = tick_results_q.size();
	end

endmodule

// ----- sim/tb.sv -----
module tb;
	import crft_pkg::*;

	localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 3000;
	localparam int NUM_PHASES = 8;
	// directed beats as {action, sensor_level} pairs, first beat in the top bits
	localparam logic [47:0] DIRECTED =
		48'b00_01_11_01_01_00_00_00_00_00_00_00_10_00_00_01_00_01_00_01_10_00_01_01;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                action = 1'b0;
	logic                sensor_level = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                active_drive;
	logic                sensor_drive_enable;
	logic                sensor_drive_high;
	logic                busy_res;
	logic                done_res;
	logic [EdgeW-1:0]    reading;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	int n_fail;
	int n_pending;

	int          phase_samples [NUM_PHASES] = '{4, 3, 1, 255, 'h1FF03, 16, 1, 0};
	int          phase_settle  [NUM_PHASES] = '{2, 1, 3, 1, 'h10002, 20, 65535, 0};
	int          phase_timeout [NUM_PHASES] = '{6, 0, 131071, 12, 8, 70000, 50, 1};
	int          phase_beats   [NUM_PHASES] = '{200, 120, 150, 250, 200, 200, 100, 120};

	bit          calm = 1'b0;
	int          hold_ask = 0;
	int          hold_given = 0;
	int unsigned done_cnt = 0;
	int          idle_cycles = 0;

	always #5 clk = ~clk;

	capacitive_rise_fall_timer_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.sensor_level(sensor_level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.active_drive(active_drive),
		.sensor_drive_enable(sensor_drive_enable),
		.sensor_drive_high(sensor_drive_high),
		.busy_res(busy_res),
		.done_res(done_res),
		.reading(reading),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	crft_checker u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.sensor_level(sensor_level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.active_drive(active_drive),
		.sensor_drive_enable(sensor_drive_enable),
		.sensor_drive_high(sensor_drive_high),
		.busy_res(busy_res),
		.done_res(done_res),
		.reading(reading),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.n_fail(n_fail),
		.n_pending(n_pending)
	);

	// called and returns on a falling edge
	task automatic send_item(input logic a, input logic l);
		int r;
		int gap;
		r = $urandom_range(0, 99);
		if (calm || r < 70)
			gap = 0;
		else if (r < 95)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 40);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		action <= a;
		sensor_level <= l;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain_results();
		while (n_pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	always @(posedge clk)
		if (out_valid && !out_stall && done_res)
			done_cnt <= done_cnt + 1;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == IDLE_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// result side back-pressure, with one long hold-off on request
	initial begin
		int r;
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_ask != hold_given) begin
				hold_given = hold_ask;
				n = 120;
			end else if (calm) begin
				n = 0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 65)
					n = 0;
				else if (r < 93)
					n = $urandom_range(1, 3);
				else
					n = $urandom_range(8, 30);
			end
			if (n != 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		int          p;
		int          i;
		int          cnt;
		int          r;
		int          run_left;
		logic        lvl;
		logic        l;
		logic        a;
		bit          open;
		int unsigned start_mark;
		run_left = 0;
		lvl = 1'b0;
		start_mark = 0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		cfg_write(CFG_SAMPLE_COUNT, CfgDataW'(2));
		cfg_write(CFG_SETTLE_TICKS, CfgDataW'(0));
		cfg_write(CFG_TIMEOUT_COUNT, CfgDataW'(4));
		for (i = 0; i < 24; i++)
			send_item(DIRECTED[47-2*i], DIRECTED[46-2*i]);
		in_valid <= 1'b0;

		for (p = 0; p < NUM_PHASES; p++) begin
			drain_results();
			if (p == 4)
				cfg_write(CFG_UNUSED, CfgDataW'($urandom_range(0, 131071)));
			cfg_write(CFG_SAMPLE_COUNT, CfgDataW'(phase_samples[p]));
			cfg_write(CFG_SETTLE_TICKS, CfgDataW'(phase_settle[p]));
			cfg_write(CFG_TIMEOUT_COUNT, CfgDataW'(phase_timeout[p]));
			calm = p[0];
			if (p == 0)
				hold_ask = hold_ask + 1;
			cnt = 0;
			while (cnt < phase_beats[p]) begin
				open = (done_cnt == start_mark);
				// mostly full readings, with an occasional restart mid-way
				if (open)
					a = ($urandom_range(0, 199) == 0);
				else
					a = ($urandom_range(0, 3) == 0);
				if (a)
					start_mark = done_cnt;
				// sensor as runs of one level, some long enough to time out
				if (run_left == 0) begin
					lvl = ~lvl;
					r = $urandom_range(0, 19);
					if (r < 14)
						run_left = $urandom_range(1, 5);
					else if (r < 18)
						run_left = $urandom_range(6, 15);
					else
						run_left = $urandom_range(16, 60);
				end
				run_left = run_left - 1;
				l = ($urandom_range(0, 15) == 0) ? ~lvl : lvl;
				send_item(a, l);
				if (open || a)
					cnt = cnt + 1;
			end
			in_valid <= 1'b0;
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (n_fail == 0 && n_pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
